// ===== rtl/sfr_pkg.sv =====
// Shared types and constants for the stream find-and-replace block.
package sfr_pkg;

    localparam int unsigned CFG_W    = 64;
    localparam int unsigned LEN_W    = 4;
    localparam int unsigned ADDR_W   = 2;
    localparam int unsigned BYTE_W   = 8;

    localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;

    localparam logic [ADDR_W-1:0] REG_PATTERN_BYTES      = 2'd0;
    localparam logic [ADDR_W-1:0] REG_PATTERN_LENGTH     = 2'd1;
    localparam logic [ADDR_W-1:0] REG_REPLACEMENT_BYTES  = 2'd2;
    localparam logic [ADDR_W-1:0] REG_REPLACEMENT_LENGTH = 2'd3;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_item;    // capture the accepted byte and its final flag
        logic set_newline;  // replace the working byte with the implied newline
        logic insert;       // append the working byte to the window
        logic pop;          // emit the oldest window byte and shift
        logic emit_rep;     // emit the next replacement byte
        logic rep_clear;    // restart the replacement counter
        logic clear_fill;   // empty the window after a match
        logic finish;       // hand the held byte to the output marked last
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic fill_ge_plen;
        logic fill_zero;
        logic match;
        logic rlen_zero;
        logic rep_last;
        logic byte_is_nl;
        logic fin;
        logic pend_valid;
        logic slot_free;    // an emit may proceed this cycle
    } status_t;

endpackage

// ===== rtl/stream_find_and_replace.sv =====
// Top level of the stream find-and-replace block: configuration registers and wiring.
// Usage
//   Input stream s_axis_*: one text byte per transfer; tlast marks the final
//   byte of the stream, after which a newline is implied unless that byte is one.
//   Output stream m_axis_*: the rewritten text, one byte per transfer; tlast marks
//   the last byte produced by a given input byte (inputs that produce nothing give
//   no transfer at all).
//   Configuration: write cfg_wdata to register cfg_addr while cfg_we is high
//   (0 pattern bytes, 1 pattern length, 2 replacement bytes, 3 replacement
//   length). Write only while the block is idle.
// Sequence
//   One input byte at a time. Each byte steps through the controller states: drain
//   window bytes ahead of it, insert it, check for a match, emit any replacement
//   bytes, flush the window at a newline, then repeat for an implied newline.
//   One byte is held back to attach the end mark: it moves out at the edge that
//   produces the next one, and the last byte of an item when the item finishes.
// Reset and back-pressure
//   rst_n empties the window, idles the controller and output, and loads pattern
//   length 1 with everything else zero. While m_axis_tready is low the output byte holds,
//   emits behind a held byte wait; s_axis_tready stays low until the item is done.
module stream_find_and_replace #(
    parameter int unsigned MAX_PATTERN     = 8,
    parameter int unsigned MAX_REPLACEMENT = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration write port
    input  logic                          cfg_we,
    input  logic [sfr_pkg::ADDR_W-1:0]    cfg_addr,
    input  logic [sfr_pkg::CFG_W-1:0]     cfg_wdata,
    // input stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,   // [7:0] in_byte
    input  logic                          s_axis_tlast,   // is_final
    // output stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [7:0]                    m_axis_tdata,   // [7:0] out_byte
    output logic                          m_axis_tlast    // run_end
);
    import sfr_pkg::*;

    localparam int unsigned FW = $clog2(MAX_PATTERN + 1);
    localparam int unsigned RW = $clog2(MAX_REPLACEMENT + 1);

    logic [CFG_W-1:0] pattern_bytes_reg,      pattern_bytes_next;
    logic [LEN_W-1:0] pattern_length_reg,     pattern_length_next;
    logic [CFG_W-1:0] replacement_bytes_reg,  replacement_bytes_next;
    logic [LEN_W-1:0] replacement_length_reg, replacement_length_next;

    logic [FW-1:0] plen;
    logic [RW-1:0] rlen;
    cmd_t          cmd;
    status_t       st;

    // Decode a configuration write; all four indexes name a register, so default is unused.
    always_comb
    begin
        pattern_bytes_next      = pattern_bytes_reg;
        pattern_length_next     = pattern_length_reg;
        replacement_bytes_next  = replacement_bytes_reg;
        replacement_length_next = replacement_length_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                REG_PATTERN_BYTES:      pattern_bytes_next      = cfg_wdata;
                REG_PATTERN_LENGTH:     pattern_length_next     = cfg_wdata[LEN_W-1:0];
                REG_REPLACEMENT_BYTES:  replacement_bytes_next  = cfg_wdata;
                REG_REPLACEMENT_LENGTH: replacement_length_next = cfg_wdata[LEN_W-1:0];
                default:                pattern_bytes_next      = pattern_bytes_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_bytes_reg      <= '0;
            pattern_length_reg     <= LEN_W'(1);
            replacement_bytes_reg  <= '0;
            replacement_length_reg <= '0;
        end
        else
        begin
            pattern_bytes_reg      <= pattern_bytes_next;
            pattern_length_reg     <= pattern_length_next;
            replacement_bytes_reg  <= replacement_bytes_next;
            replacement_length_reg <= replacement_length_next;
        end
    end

    // Effective lengths: a zero pattern length counts as one, both saturate.
    always_comb
    begin
        if (pattern_length_reg == '0)
        begin
            plen = FW'(1);
        end
        else if (pattern_length_reg > LEN_W'(MAX_PATTERN))
        begin
            plen = FW'(MAX_PATTERN);
        end
        else
        begin
            plen = FW'(pattern_length_reg);
        end

        if (replacement_length_reg > LEN_W'(MAX_REPLACEMENT))
        begin
            rlen = RW'(MAX_REPLACEMENT);
        end
        else
        begin
            rlen = RW'(replacement_length_reg);
        end
    end

    sfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .st       (st),
        .cmd      (cmd)
    );

    sfr_datapath #(
        .MAX_PATTERN     (MAX_PATTERN),
        .MAX_REPLACEMENT (MAX_REPLACEMENT),
        .FW              (FW),
        .RW              (RW)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_byte           (s_axis_tdata),
        .in_final          (s_axis_tlast),
        .pattern_bytes     (pattern_bytes_reg),
        .plen              (plen),
        .replacement_bytes (replacement_bytes_reg),
        .rlen              (rlen),
        .cmd               (cmd),
        .st                (st),
        .out_valid         (m_axis_tvalid),
        .out_ready         (m_axis_tready),
        .out_byte          (m_axis_tdata),
        .out_last          (m_axis_tlast)
    );

endmodule

// ===== rtl/sfr_ctrl.sv =====
// Controller state machine that sequences the window operations of one byte.
module sfr_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  sfr_pkg::status_t st,
    output sfr_pkg::cmd_t    cmd
);
    import sfr_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PRE   = 3'd1;
    localparam logic [2:0] ST_CHECK = 3'd2;
    localparam logic [2:0] ST_REP   = 3'd3;
    localparam logic [2:0] ST_FLUSH = 3'd4;
    localparam logic [2:0] ST_FIN   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_PRE;
                end
            end
            ST_PRE:
            begin
                // drain down below the pattern length, then take the byte
                if (st.fill_ge_plen)
                begin
                    cmd.pop = st.slot_free;
                end
                else
                begin
                    cmd.insert = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (st.match)
                begin
                    cmd.clear_fill = 1'b1;
                    cmd.rep_clear  = 1'b1;
                    state_next     = st.rlen_zero ? ST_FLUSH : ST_REP;
                end
                else if (st.fill_ge_plen)
                begin
                    if (st.slot_free)
                    begin
                        cmd.pop    = 1'b1;
                        state_next = ST_FLUSH;
                    end
                end
                else
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_REP:
            begin
                if (st.slot_free)
                begin
                    cmd.emit_rep = 1'b1;
                    if (st.rep_last)
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (st.byte_is_nl && !st.fill_zero)
                begin
                    cmd.pop = st.slot_free;
                end
                else if (st.fin && !st.byte_is_nl)
                begin
                    cmd.set_newline = 1'b1;
                    state_next      = ST_PRE;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!st.pend_valid)
                begin
                    state_next = ST_IDLE;
                end
                else if (st.slot_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/sfr_datapath.sv =====
// Datapath: match window, replacement counter, held byte and output register.
module sfr_datapath #(
    parameter int unsigned MAX_PATTERN     = 8,
    parameter int unsigned MAX_REPLACEMENT = 8,
    parameter int unsigned FW              = $clog2(MAX_PATTERN + 1),
    parameter int unsigned RW              = $clog2(MAX_REPLACEMENT + 1)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [sfr_pkg::BYTE_W-1:0]      in_byte,
    input  logic                            in_final,
    input  logic [sfr_pkg::CFG_W-1:0]       pattern_bytes,
    input  logic [FW-1:0]                   plen,
    input  logic [sfr_pkg::CFG_W-1:0]       replacement_bytes,
    input  logic [RW-1:0]                   rlen,
    input  sfr_pkg::cmd_t                   cmd,
    output sfr_pkg::status_t                st,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [sfr_pkg::BYTE_W-1:0]      out_byte,
    output logic                            out_last
);
    import sfr_pkg::*;

    localparam int unsigned IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    logic [BYTE_W-1:0] win_reg  [MAX_PATTERN];
    logic [BYTE_W-1:0] win_next [MAX_PATTERN];
    logic [FW-1:0]     fill_reg, fill_next;
    logic [RW-1:0]     rep_idx_reg, rep_idx_next;
    logic [BYTE_W-1:0] cur_byte_reg, cur_byte_next;
    logic              fin_reg, fin_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [BYTE_W-1:0] pend_byte_reg, pend_byte_next;
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic              out_last_reg, out_last_next;

    logic              lanes_ok;
    logic              out_free;
    logic              emit;
    logic [BYTE_W-1:0] emit_byte;

    always_comb
    begin
        lanes_ok = 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            if ((FW'(i) < plen) && (win_reg[i] != pattern_bytes[BYTE_W*i +: BYTE_W]))
            begin
                lanes_ok = 1'b0;
            end
        end
    end

    assign out_free  = !out_valid_reg || out_ready;
    assign emit      = cmd.pop || cmd.emit_rep;
    assign emit_byte = cmd.pop ? win_reg[0] : replacement_bytes[BYTE_W*rep_idx_reg +: BYTE_W];

    always_comb
    begin
        st.fill_ge_plen = (fill_reg >= plen);
        st.fill_zero    = (fill_reg == '0);
        st.match        = (fill_reg == plen) && lanes_ok;
        st.rlen_zero    = (rlen == '0);
        st.rep_last     = ((rep_idx_reg + RW'(1)) == rlen);
        st.byte_is_nl   = (cur_byte_reg == NEWLINE_BYTE);
        st.fin          = fin_reg;
        st.pend_valid   = pend_valid_reg;
        st.slot_free    = !pend_valid_reg || out_free;
    end

    always_comb
    begin
        win_next      = win_reg;
        fill_next     = fill_reg;
        rep_idx_next  = rep_idx_reg;
        cur_byte_next = cur_byte_reg;
        fin_next      = fin_reg;

        if (cmd.load_item)
        begin
            cur_byte_next = in_byte;
            fin_next      = in_final;
        end
        if (cmd.set_newline)
        begin
            cur_byte_next = NEWLINE_BYTE;
            fin_next      = 1'b0;
        end
        if (cmd.pop)
        begin
            for (int i = 0; i < MAX_PATTERN - 1; i++)
            begin
                win_next[i] = win_reg[i + 1];
            end
            fill_next = fill_reg - FW'(1);
        end
        if (cmd.insert)
        begin
            win_next[fill_reg[IDX_W-1:0]] = cur_byte_reg;
            fill_next = fill_reg + FW'(1);
        end
        if (cmd.clear_fill)
        begin
            fill_next = '0;
        end
        if (cmd.rep_clear)
        begin
            rep_idx_next = '0;
        end
        else if (cmd.emit_rep)
        begin
            rep_idx_next = rep_idx_reg + RW'(1);
        end
    end

    // One byte is held back so the last byte of an item can carry the end mark.
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_byte_next  = pend_byte_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;

        if (emit)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_byte_next  = pend_byte_reg;
                out_last_next  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_byte_next  = emit_byte;
        end
        else if (cmd.finish)
        begin
            out_valid_next  = 1'b1;
            out_byte_next   = pend_byte_reg;
            out_last_next   = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            fill_reg       <= fill_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg       <= win_next;
        rep_idx_reg   <= rep_idx_next;
        cur_byte_reg  <= cur_byte_next;
        fin_reg       <= fin_next;
        pend_byte_reg <= pend_byte_next;
        out_byte_reg  <= out_byte_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

endmodule

// ===== rtl/sfr_checker.sv =====
// Port-level assertions for the stream find-and-replace block, bound to the top level.
module sfr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast
);

    // A stalled output transfer keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output payload changed while stalled");

    // One item at a time: right after an input transfer the block is busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while previous item still in work");

    // When ready for a new item, any waiting output byte closes its run.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready && m_axis_tvalid |-> m_axis_tlast)
    else $error("idle with an unfinished run on the output");

endmodule

bind stream_find_and_replace sfr_checker u_sfr_checker (.*);

// ===== tb/stream_find_and_replace_tb.sv =====
// Self-checking testbench for stream_find_and_replace: directed and random text.
module stream_find_and_replace_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sfr_pkg::*;

    localparam int unsigned MAX_PAT       = 8;
    localparam int unsigned MAX_REP       = 8;
    localparam int unsigned SETTLE_CYCLES = 20;    // an item with no output may still be in flight
    localparam int unsigned QUIET_LIMIT   = 1000;  // cycles with no transfer on either side
    localparam int unsigned PRINT_LIMIT   = 40;

    // One output transfer as the model predicts it.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } text_beat_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_W-1:0]  cfg_wdata = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata = '0;
    logic              s_axis_tlast = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [7:0]        m_axis_tdata;
    logic              m_axis_tlast;

    // Random idling on both sides; cleared for one steady stretch.
    logic gaps_on = 1'b1;

    // Model state: register copies and the match window, oldest byte first.
    logic [63:0]  pat_q = '0;
    logic [3:0]   pat_len_q = 4'd1;
    logic [63:0]  rep_q = '0;
    logic [3:0]   rep_len_q = 4'd0;
    logic [7:0]   win_q [$];

    text_beat_t   text_due [$];   // rewritten text still owed by the block, oldest first
    text_beat_t   item_text [$];  // text caused by the byte being rewritten
    text_beat_t   head_beat;
    int unsigned  mismatches = 0;
    int unsigned  quiet_cycles = 0;

    stream_find_and_replace dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Model of the rewrite
    // ------------------------------------------------------------------

    // Pattern length as the block uses it: zero reads as one, large values saturate.
    function automatic int unsigned pattern_span();
        int unsigned n;
        n = 32'(pat_len_q);
        if (n == 0) n = 1;
        if (n > MAX_PAT) n = MAX_PAT;
        return n;
    endfunction

    function automatic void emit_text(input logic [7:0] b);
        text_beat_t t;
        t.data = b;
        t.last = 1'b0;
        item_text.push_back(t);
    endfunction

    // Emit the oldest window byte unchanged and close the gap.
    function automatic void shift_oldest();
        if (win_q.size() == 0) return;
        emit_text(win_q.pop_front());
    endfunction

    function automatic logic window_hits(input int unsigned plen);
        int unsigned i;
        if (win_q.size() != plen) return 1'b0;
        for (i = 0; i < plen; i++)
            if (win_q[i] != pat_q[8*i +: 8]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic void absorb_byte(input logic [7:0] b);
        int unsigned plen;
        int unsigned rlen;
        int unsigned i;
        plen = pattern_span();
        // a pattern shortened since the last byte leaves surplus bytes to drain
        while (win_q.size() >= plen) shift_oldest();
        win_q.push_back(b);
        if (window_hits(plen)) begin
            rlen = (32'(rep_len_q) > MAX_REP) ? MAX_REP : 32'(rep_len_q);
            for (i = 0; i < rlen; i++) emit_text(rep_q[8*i +: 8]);
            win_q.delete();
        end
        else if (win_q.size() >= plen) begin
            shift_oldest();
        end
        // no match spans a line end: flush what is left
        if (b == NEWLINE_BYTE)
            while (win_q.size() > 0) shift_oldest();
    endfunction

    // Work out the text caused by one input transfer and queue it.
    function automatic void rewrite_byte(input logic [7:0] b, input logic fin);
        text_beat_t t;
        int unsigned k;
        item_text.delete();
        absorb_byte(b);
        if (fin && b != NEWLINE_BYTE) absorb_byte(NEWLINE_BYTE);
        if (item_text.size() > 0) begin
            t = item_text[item_text.size()-1];
            t.last = 1'b1;
            item_text[item_text.size()-1] = t;
        end
        for (k = 0; k < item_text.size(); k++) text_due.push_back(item_text[k]);
    endfunction

    function automatic logic [63:0] pack_text(input string s);
        logic [63:0] v;
        int i;
        v = '0;
        for (i = 0; i < s.len() && i < 8; i++) v[8*i +: 8] = s[i];
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Offer one byte, hold it until the block takes it, then predict its text.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        while (gaps_on && $urandom_range(99) < 17) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= fin;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        rewrite_byte(b, fin);
    endtask

    task automatic send_text(input string s, input logic fin_on_last);
        int i;
        for (i = 0; i < s.len(); i++)
            send_byte(s[i], fin_on_last && (i == s.len() - 1));
    endtask

    // Drop valid, wait for every owed byte, then let a silent item finish.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (text_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all four registers back to back; call only while the block is idle.
    task automatic load_config(input logic [63:0] pb, input logic [63:0] pl,
                               input logic [63:0] rb, input logic [63:0] rl);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_PATTERN_BYTES;
        cfg_wdata <= pb;
        @(posedge clk);
        cfg_addr  <= REG_PATTERN_LENGTH;
        cfg_wdata <= pl;
        @(posedge clk);
        cfg_addr  <= REG_REPLACEMENT_BYTES;
        cfg_wdata <= rb;
        @(posedge clk);
        cfg_addr  <= REG_REPLACEMENT_LENGTH;
        cfg_wdata <= rl;
        @(posedge clk);
        cfg_we    <= 1'b0;
        pat_q     = pb;
        pat_len_q = pl[3:0];
        rep_q     = rb;
        rep_len_q = rl[3:0];
    endtask

    // Receiver: stall at random unless the steady stretch is on.
    always @(posedge clk)
        m_axis_tready <= !gaps_on || ($urandom_range(99) >= 17);

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_LIMIT) $display("%0t ns mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // Compare each output transfer with the oldest owed byte.
    always @(posedge clk) begin
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (text_due.size() == 0) begin
                report_mismatch($sformatf("unexpected byte %02h last %0b",
                                          m_axis_tdata, m_axis_tlast));
            end
            else begin
                head_beat = text_due.pop_front();
                if (m_axis_tdata !== head_beat.data)
                    report_mismatch($sformatf("out_byte %02h, model %02h",
                                              m_axis_tdata, head_beat.data));
                if (m_axis_tlast !== head_beat.last)
                    report_mismatch($sformatf("run_end %0b on byte %02h, model %0b",
                                              m_axis_tlast, m_axis_tdata, head_beat.last));
            end
        end
    end

    // Watchdog: end the run once nothing has moved for too long.
    always @(posedge clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values: pattern is a single zero byte, replacement is empty, so zeros vanish.
    task automatic test_reset_defaults();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h41, 1'b1);   // final byte that is not a newline: newline implied
    endtask

    // Plain replacement, back-to-back matches, a final newline and an implied one.
    task automatic test_replace_basics();
        wait_idle();
        load_config(pack_text("ab"), 64'd2, pack_text("XYZ"), 64'd3);
        send_text("xabab", 1'b0);
        send_byte(NEWLINE_BYTE, 1'b1);   // final newline: nothing added
        send_text("aab", 1'b1);
    endtask

    // Zero pattern length reads as one; replacement length above the maximum saturates.
    task automatic test_length_limits();
        wait_idle();
        load_config(pack_text("q"), 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'd12);
        send_byte("q", 1'b0);
    endtask

    // Pattern ending in a newline, deleted by an empty replacement; also via the
    // implied newline after a final byte.
    task automatic test_newline_patterns();
        wait_idle();
        load_config(pack_text("z\n"), 64'd2, 64'd0, 64'd0);
        send_text("z\n", 1'b0);
        send_text("yz", 1'b1);
    endtask

    // Fill the window under a long pattern, then shorten it while bytes are held.
    task automatic test_shortened_pattern();
        wait_idle();
        load_config(pack_text("ABCDEFGH"), 64'd15, pack_text("-"), 64'd1);
        send_text("abcde", 1'b0);
        wait_idle();
        load_config(pack_text("ABCDEFGH"), 64'd2, pack_text("-"), 64'd1);
        send_byte("f", 1'b0);
        send_byte(NEWLINE_BYTE, 1'b0);
    endtask

    // Pick pattern and replacement for one random phase.
    task automatic pick_random_config(input int unsigned phase);
        logic [63:0] pb;
        logic [63:0] rb;
        logic [63:0] pl;
        logic [63:0] rl;
        int unsigned i;
        case ($urandom_range(5))
            0: pb = '1;
            1: pb = '0;
            2: pb = {$urandom, $urandom};
            default:
                // small alphabet so text matches often, with a stray newline now and then
                for (i = 0; i < 8; i++)
                    pb[8*i +: 8] = ($urandom_range(9) == 0) ? NEWLINE_BYTE
                                                            : 8'h61 + 8'($urandom_range(2));
        endcase
        case ($urandom_range(3))
            0: rb = '1;
            1: rb = '0;
            default: rb = {$urandom, $urandom};
        endcase
        // junk above the length field is dropped by the block
        pl = ($urandom_range(3) == 0) ? {$urandom, $urandom} : 64'd0;
        rl = ($urandom_range(3) == 0) ? {$urandom, $urandom} : 64'd0;
        if (phase == 0)
            pl[3:0] = 4'd1;
        else if (phase == 1)
            pl[3:0] = 4'd8;
        else if ($urandom_range(6) == 0)
            pl[3:0] = 4'($urandom_range(15));
        else
            pl[3:0] = 4'($urandom_range(8, 1));
        rl[3:0] = (phase == 1) ? 4'd8 : 4'($urandom_range(15));
        load_config(pb, pl, rb, rl);
    endtask

    // Mostly whole patterns with random spoiling, mixed with pattern bytes,
    // newlines and arbitrary bytes.
    task automatic send_random_text(input int unsigned n);
        int unsigned sent;
        int unsigned plen;
        int unsigned j;
        int unsigned roll;
        logic [7:0]  b;
        sent = 0;
        while (sent < n) begin
            plen = pattern_span();
            roll = $urandom_range(99);
            if (roll < 35) begin
                for (j = 0; j < plen; j++) begin
                    b = pat_q[8*j +: 8];
                    if ($urandom_range(9) == 0) b = 8'($urandom);
                    send_byte(b, $urandom_range(49) == 0);
                end
                sent += plen;
            end
            else begin
                if (roll < 45)
                    b = NEWLINE_BYTE;
                else if (roll < 80)
                    b = pat_q[8*$urandom_range(plen - 1) +: 8];
                else
                    b = 8'($urandom);
                send_byte(b, $urandom_range(32) == 0);
                sent++;
            end
        end
    endtask

    // Several random configurations; each phase starts from an idle block,
    // one phase runs with no idling on either side.
    task automatic test_random_traffic();
        int unsigned phase;
        for (phase = 0; phase < 7; phase++) begin
            wait_idle();
            gaps_on <= (phase != 2);
            pick_random_config(phase);
            send_random_text(60);
        end
        gaps_on <= 1'b1;
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_replace_basics();
        test_length_limits();
        test_newline_patterns();
        test_shortened_pattern();
        test_random_traffic();

        wait_idle();
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/sfr_pkg.sv
rtl/sfr_ctrl.sv
rtl/sfr_datapath.sv
rtl/stream_find_and_replace.sv
rtl/sfr_checker.sv
tb/stream_find_and_replace_tb.sv
